FILE: rtl/ordered_list_table_engine_core_assert.svh
// Assertion macros for the ordered list table engine.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ORDERED_LIST_TABLE_ENGINE_CORE_ASSERT_SVH
`define ORDERED_LIST_TABLE_ENGINE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Consequent must hold in the same cycle as the antecedent.
`define OLTAB_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("oltab assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define OLTAB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("oltab assertion failed");
`else
`define OLTAB_ASSERT_SAME(label, clk, rst, ante, cons)
`define OLTAB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/oltab_pkg.sv
// Shared constants and types of the ordered list table engine.
// Depends on nothing; used by the channel interfaces and the core.
package oltab_pkg;

   // Storage size and derived widths.
   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // Fixed field widths of the channels.
   localparam int REQ_W    = 3;
   localparam int POS_W    = 6;
   localparam int VAL_W    = 32;
   localparam int STAT_W   = 3;
   localparam int CNTO_W   = 7;

   // Width wide enough to compare a position against the count.
   localparam int CMP_W    = (POS_W + 1 > CNT_W) ? POS_W + 1 : CNT_W;

   typedef enum logic [REQ_W-1:0] {
      RQ_APPEND = 3'd0,
      RQ_INSERT = 3'd1,
      RQ_SET    = 3'd2,
      RQ_REMOVE = 3'd3,
      RQ_GET    = 3'd4,
      RQ_FIND   = 3'd5,
      RQ_CLEAR  = 3'd6
   } req_code_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 3'd0,
      ST_BAD_INDEX = 3'd1,
      ST_FULL      = 3'd2,
      ST_NULL      = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_INS_LAST,
      S_DONE
   } state_type;

endpackage

FILE: rtl/oltab_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on oltab_pkg for the field widths.
interface oltab_req_if;
   import oltab_pkg::*;

   logic             valid;
   logic             ready;
   logic [REQ_W-1:0] req_type;
   logic [POS_W-1:0] position;
   logic [VAL_W-1:0] value;

   modport source (output valid, output req_type, output position, output value,
                   input ready);
   modport sink   (input valid, input req_type, input position, input value,
                   output ready);
endinterface

interface oltab_rsp_if;
   import oltab_pkg::*;

   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [VAL_W-1:0]  data;
   logic [POS_W-1:0]  found_position;
   logic [CNTO_W-1:0] entry_count;

   modport source (output valid, output status, output data, output found_position,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input data, input found_position,
                   input entry_count, output ready);
endinterface

FILE: rtl/oltab_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module oltab_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/ordered_list_table_engine_core.sv
// Append, set, clear, insert at the end and rejected items go from accept straight to S_DONE;
// get, remove, find and other inserts first walk the entry RAM in S_RUN, and such an insert
// also passes S_INS_LAST. The core takes one item at a time: a new request is accepted only in
// S_IDLE, and each walk is paced by the single read and single write port of the entry RAM.
// Reset is synchronous and clears the count and control; entry RAM is not cleared.
// Depends on oltab_pkg, oltab_if, oltab_ram and the assertion header.
`include "ordered_list_table_engine_core_assert.svh"

module ordered_list_table_engine_core (
   input  logic      clock,
   input  logic      reset,
   oltab_req_if.sink req_chan,
   oltab_rsp_if.source rsp_chan
);
   import oltab_pkg::*;

   state_type         state_ff, state_in;
   req_code_type      op_ff, op_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [VAL_W-1:0]  val_ff, val_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic              iss_ff, iss_in;
   logic              rd_valid_ff, rd_valid_in;
   logic [ADDR_W-1:0] rd_tag_ff, rd_tag_in;
   status_type        res_status_ff, res_status_in;
   logic [VAL_W-1:0]  res_data_ff, res_data_in;
   logic [ADDR_W-1:0] res_where_ff, res_where_in;
   logic              out_valid_ff, out_valid_in;
   status_type        out_status_ff, out_status_in;
   logic [VAL_W-1:0]  out_data_ff, out_data_in;
   logic [ADDR_W-1:0] out_where_ff, out_where_in;
   logic [CNT_W-1:0]  out_count_ff, out_count_in;

   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [VAL_W-1:0]  mem_wdata;
   logic [ADDR_W-1:0] mem_raddr;
   logic [VAL_W-1:0]  mem_rdata;

   req_code_type      req_code;
   logic              needs_value;
   logic              cnt_full;
   logic [CNT_W-1:0]  cnt_last;
   logic [CMP_W-1:0]  pos_cmp, cnt_cmp;
   logic              out_free;
   logic              last_issue;
   logic              req_ready;
   logic              walk_read;
   logic              clear_fire;

   // Entry storage.
   oltab_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_entries (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Request decode helpers.
   assign req_code    = req_code_type'(req_chan.req_type);
   assign needs_value = (req_code == RQ_APPEND) || (req_code == RQ_INSERT) ||
                        (req_code == RQ_SET) || (req_code == RQ_FIND);
   assign cnt_full    = (cnt_ff == CNT_W'(CAPACITY));
   assign cnt_last    = cnt_ff - CNT_W'(1);
   assign pos_cmp     = CMP_W'(req_chan.position);
   assign cnt_cmp     = CMP_W'(cnt_ff);
   assign out_free    = !out_valid_ff || rsp_chan.ready;

   // State register and control.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         iss_ff       <= 1'b0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         iss_ff       <= iss_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      rd_addr_ff    <= rd_addr_in;
      rd_tag_ff     <= rd_tag_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      res_where_ff  <= res_where_in;
      out_status_ff <= out_status_in;
      out_data_ff   <= out_data_in;
      out_where_ff  <= out_where_in;
      out_count_ff  <= out_count_in;
   end

   // Sequencer: next state, RAM accesses and result staging.
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      cnt_in        = cnt_ff;
      rd_addr_in    = rd_addr_ff;
      iss_in        = iss_ff;
      rd_valid_in   = 1'b0;
      rd_tag_in     = rd_tag_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      res_where_in  = res_where_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;
      out_status_in = out_status_ff;
      out_data_in   = out_data_ff;
      out_where_in  = out_where_ff;
      out_count_in  = out_count_ff;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff;
      mem_wdata     = val_ff;
      mem_raddr     = rd_addr_ff;
      last_issue    = 1'b1;
      req_ready     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_chan.valid) begin
               op_in         = req_code;
               pos_in        = ADDR_W'(req_chan.position);
               val_in        = req_chan.value;
               res_status_in = ST_OK;
               res_data_in   = '0;
               res_where_in  = '0;
               state_in      = S_DONE;
               if (needs_value && (req_chan.value == '0)) begin
                  res_status_in = ST_NULL;
               end else begin
                  unique case (req_code)
                     RQ_APPEND: begin
                        if (cnt_full) begin
                           res_status_in = ST_FULL;
                        end else begin
                           mem_we    = 1'b1;
                           mem_waddr = ADDR_W'(cnt_ff);
                           mem_wdata = req_chan.value;
                           cnt_in    = cnt_ff + CNT_W'(1);
                        end
                     end
                     RQ_INSERT: begin
                        if (pos_cmp > cnt_cmp) begin
                           res_status_in = ST_BAD_INDEX;
                        end else if (cnt_full) begin
                           res_status_in = ST_FULL;
                        end else if (pos_cmp == cnt_cmp) begin
                           // Insert at the end needs no shift.
                           mem_we    = 1'b1;
                           mem_waddr = ADDR_W'(req_chan.position);
                           mem_wdata = req_chan.value;
                           cnt_in    = cnt_ff + CNT_W'(1);
                        end else begin
                           // Shift entries up, starting from the last one.
                           rd_addr_in = ADDR_W'(cnt_last);
                           iss_in     = 1'b1;
                           state_in   = S_RUN;
                        end
                     end
                     RQ_SET: begin
                        if (pos_cmp >= cnt_cmp) begin
                           res_status_in = ST_BAD_INDEX;
                        end else begin
                           mem_we    = 1'b1;
                           mem_waddr = ADDR_W'(req_chan.position);
                           mem_wdata = req_chan.value;
                        end
                     end
                     RQ_REMOVE, RQ_GET: begin
                        if (pos_cmp >= cnt_cmp) begin
                           res_status_in = ST_BAD_INDEX;
                        end else begin
                           rd_addr_in = ADDR_W'(req_chan.position);
                           iss_in     = 1'b1;
                           state_in   = S_RUN;
                        end
                     end
                     RQ_FIND: begin
                        if (cnt_ff == '0) begin
                           res_status_in = ST_NOT_FOUND;
                        end else begin
                           rd_addr_in = '0;
                           iss_in     = 1'b1;
                           state_in   = S_RUN;
                        end
                     end
                     RQ_CLEAR: begin
                        cnt_in = '0;
                     end
                     default: begin
                        // The unused code changes nothing and answers ok.
                     end
                  endcase
               end
            end
         end

         S_RUN: begin
            // Issue the next read of the walk.
            if (iss_ff) begin
               mem_raddr   = rd_addr_ff;
               rd_valid_in = 1'b1;
               rd_tag_in   = rd_addr_ff;
               case (op_ff)
                  RQ_INSERT: begin
                     last_issue = (rd_addr_ff == pos_ff);
                     rd_addr_in = rd_addr_ff - ADDR_W'(1);
                  end
                  RQ_REMOVE, RQ_FIND: begin
                     last_issue = (CNT_W'(rd_addr_ff) == cnt_last);
                     rd_addr_in = rd_addr_ff + ADDR_W'(1);
                  end
                  default: begin
                     last_issue = 1'b1;
                  end
               endcase
               iss_in = !last_issue;
            end

            // Handle the entry read in the previous cycle.
            if (rd_valid_ff) begin
               case (op_ff)
                  RQ_INSERT: begin
                     mem_we    = 1'b1;
                     mem_waddr = rd_tag_ff + ADDR_W'(1);
                     mem_wdata = mem_rdata;
                     if (rd_tag_ff == pos_ff) begin
                        state_in = S_INS_LAST;
                     end
                  end
                  RQ_REMOVE: begin
                     if (rd_tag_ff == pos_ff) begin
                        res_data_in = mem_rdata;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = rd_tag_ff - ADDR_W'(1);
                        mem_wdata = mem_rdata;
                     end
                     if (CNT_W'(rd_tag_ff) == cnt_last) begin
                        cnt_in   = cnt_last;
                        state_in = S_DONE;
                     end
                  end
                  RQ_GET: begin
                     res_data_in = mem_rdata;
                     state_in    = S_DONE;
                  end
                  RQ_FIND: begin
                     if (mem_rdata == val_ff) begin
                        res_status_in = ST_OK;
                        res_where_in  = rd_tag_ff;
                        state_in      = S_DONE;
                     end else if (CNT_W'(rd_tag_ff) == cnt_last) begin
                        res_status_in = ST_NOT_FOUND;
                        state_in      = S_DONE;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_INS_LAST: begin
            // The gap is open; place the new handle.
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = val_ff;
            cnt_in    = cnt_ff + CNT_W'(1);
            state_in  = S_DONE;
         end

         S_DONE: begin
            // Move the result into the output register once it is free.
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = res_status_ff;
               out_data_in   = res_data_ff;
               out_where_in  = res_where_ff;
               out_count_in  = cnt_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Channel outputs.
   assign req_chan.ready          = req_ready;
   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.status         = out_status_ff;
   assign rsp_chan.data           = out_data_ff;
   assign rsp_chan.found_position = POS_W'(out_where_ff);
   assign rsp_chan.entry_count    = CNTO_W'(out_count_ff);

   // Terms watched by the checks.
   assign walk_read  = (state_ff == S_RUN) && rd_valid_ff;
   assign clear_fire = req_chan.valid && req_chan.ready && (req_code == RQ_CLEAR);

   // Checks on the sequencer.
   `OLTAB_ASSERT_SAME(a_count_range, clock, reset, 1'b1, cnt_ff <= CNT_W'(CAPACITY))
   `OLTAB_ASSERT_SAME(a_read_in_list, clock, reset, walk_read, CNT_W'(rd_tag_ff) < cnt_ff)
   `OLTAB_ASSERT_SAME(a_done_no_write, clock, reset, state_ff == S_DONE, !mem_we)
   `OLTAB_ASSERT_NEXT(a_clear_empties, clock, reset, clear_fire, cnt_ff == '0)
endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the ordered list table engine: directed and random requests
// go through the request channel, and every response is checked against a handle list model.
// Depends on oltab_pkg, the oltab_req_if and oltab_rsp_if interfaces, and the core.
module tb_top;
   import oltab_pkg::*;

   // Request type that the block does not define; it must act as a no-op.
   localparam logic [REQ_W-1:0] RQ_UNUSED = 3'd7;

   // One predicted response item.
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [VAL_W-1:0]  data;
      logic [POS_W-1:0]  found_position;
      logic [CNTO_W-1:0] entry_count;
   } answer_type;

   // Handle list model plus the queue of responses that are still due.
   class handle_list_model;
      logic [VAL_W-1:0] handles [CAPACITY];
      int               used;
      answer_type       answers_due [$];
      int               errors;

      function new();
         used    = 0;
         errors  = 0;
      endfunction

      // Apply one accepted request to the list and queue its response.
      function void note_request(logic [REQ_W-1:0] kind, logic [POS_W-1:0] pos,
                                 logic [VAL_W-1:0] val);
         answer_type a;
         int         i;
         bit         takes_value;
         a = '0;
         a.status = ST_OK;
         takes_value = (kind == RQ_APPEND) || (kind == RQ_INSERT) ||
                       (kind == RQ_SET) || (kind == RQ_FIND);
         if (takes_value && val == '0) begin
            a.status = ST_NULL;
         end else begin
            case (kind)
               RQ_APPEND: begin
                  if (used >= CAPACITY) begin
                     a.status = ST_FULL;
                  end else begin
                     handles[used] = val;
                     used++;
                  end
               end
               RQ_INSERT: begin
                  if (int'(pos) > used) begin
                     a.status = ST_BAD_INDEX;
                  end else if (used >= CAPACITY) begin
                     a.status = ST_FULL;
                  end else begin
                     for (i = used; i > int'(pos); i--)
                        handles[i] = handles[i-1];
                     handles[pos] = val;
                     used++;
                  end
               end
               RQ_SET: begin
                  if (int'(pos) >= used) a.status = ST_BAD_INDEX;
                  else handles[pos] = val;
               end
               RQ_REMOVE: begin
                  if (int'(pos) >= used) begin
                     a.status = ST_BAD_INDEX;
                  end else begin
                     a.data = handles[pos];
                     for (i = int'(pos); i + 1 < used; i++)
                        handles[i] = handles[i+1];
                     used--;
                  end
               end
               RQ_GET: begin
                  if (int'(pos) >= used) a.status = ST_BAD_INDEX;
                  else a.data = handles[pos];
               end
               RQ_FIND: begin
                  a.status = ST_NOT_FOUND;
                  for (i = 0; i < used; i++) begin
                     if (handles[i] == val) begin
                        a.status = ST_OK;
                        a.found_position = i[POS_W-1:0];
                        break;
                     end
                  end
               end
               RQ_CLEAR: begin
                  used = 0;
               end
               default: begin
               end
            endcase
         end
         a.entry_count = used[CNTO_W-1:0];
         answers_due.push_back(a);
      endfunction

      // Count one failure and print it.
      function void flag(string what, logic [VAL_W-1:0] exp_val, logic [VAL_W-1:0] act_val);
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what,
                  exp_val, act_val);
      endfunction

      // Compare one accepted response item with the oldest prediction.
      function void check_response(logic [STAT_W-1:0] status, logic [VAL_W-1:0] data,
                                   logic [POS_W-1:0] found, logic [CNTO_W-1:0] entry_count);
         answer_type a;
         if (answers_due.size() == 0) begin
            errors++;
            $display("%0t: response with no request pending, expected none, actual status %0d",
                     $time, status);
            return;
         end
         a = answers_due.pop_front();
         if (status !== a.status) flag("status", a.status, status);
         if (data !== a.data) flag("data", a.data, data);
         if (found !== a.found_position) flag("found_position", a.found_position, found);
         if (entry_count !== a.entry_count) flag("entry_count", a.entry_count, entry_count);
      endfunction

      function int pending();
         return answers_due.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   steady;
   int   stall_left;

   handle_list_model list_model;

   oltab_req_if req_if ();
   oltab_rsp_if rsp_if ();

   ordered_list_table_engine_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard limit on the run time.
   initial begin
      #8000000;
      $display("status: fail");
      $finish;
   end

   // Gap length: mostly none or short, a few long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Response side: random stalls, none during the steady stretch.
   initial begin
      rsp_if.ready = 1'b0;
      stall_left   = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
         end else if (!steady && $urandom_range(0, 99) < 15) begin
            stall_left = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 2)
                                                      : $urandom_range(7, 39);
            rsp_if.ready = 1'b0;
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   // Check every accepted response item.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         list_model.check_response(rsp_if.status, rsp_if.data, rsp_if.found_position,
                                   rsp_if.entry_count);
   end

   // Offer one request item and wait until the block takes it.
   task automatic send_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] val);
      @(negedge clock);
      req_if.valid    = 1'b1;
      req_if.req_type = kind;
      req_if.position = pos;
      req_if.value    = val;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      list_model.note_request(kind, pos, val);
   endtask

   // Drop valid for a number of cycles; zero keeps the next item back to back.
   task automatic pause_requests(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_if.valid = 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // Nonzero random handle.
   function automatic logic [VAL_W-1:0] fresh_handle();
      logic [VAL_W-1:0] v;
      v = $urandom;
      if (v == '0) v = 32'h1;
      return v;
   endfunction

   // Handle already in the list, or a fresh one when the list is empty.
   function automatic logic [VAL_W-1:0] stored_handle();
      if (list_model.used == 0) return fresh_handle();
      return list_model.handles[$urandom_range(0, list_model.used - 1)];
   endfunction

   // One random request, biased to fill the list or to drain it.
   task automatic send_random(input bit growing);
      logic [REQ_W-1:0] kind;
      logic [POS_W-1:0] pos;
      logic [VAL_W-1:0] val;
      int               r;
      int               span;
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 6) begin
         // Noise: any code, any position, any value.
         kind = REQ_W'($urandom_range(0, 7));
         pos  = POS_W'($urandom_range(0, 63));
         val  = ($urandom_range(0, 3) == 0) ? '0 : $urandom;
      end else begin
         if (growing) begin
            if (r < 45) kind = RQ_APPEND;
            else if (r < 80) kind = RQ_INSERT;
            else if (r < 86) kind = RQ_SET;
            else if (r < 92) kind = RQ_GET;
            else if (r < 97) kind = RQ_FIND;
            else kind = RQ_REMOVE;
         end else begin
            if (r < 40) kind = RQ_REMOVE;
            else if (r < 55) kind = RQ_GET;
            else if (r < 70) kind = RQ_FIND;
            else if (r < 80) kind = RQ_SET;
            else if (r < 87) kind = RQ_APPEND;
            else if (r < 94) kind = RQ_INSERT;
            else if (r < 97) kind = RQ_CLEAR;
            else kind = RQ_UNUSED;
         end
         // Mostly legal positions; insert may also use the end of the list.
         span = (kind == RQ_INSERT) ? list_model.used : list_model.used - 1;
         if (span >= 0 && $urandom_range(0, 99) < 85) pos = POS_W'($urandom_range(0, span));
         else pos = POS_W'($urandom_range(0, 63));
         // Finds and some writes reuse stored handles to get hits and duplicates.
         if (kind == RQ_FIND) val = ($urandom_range(0, 99) < 70) ? stored_handle()
                                                                : fresh_handle();
         else val = ($urandom_range(0, 99) < 20) ? stored_handle() : fresh_handle();
         if ($urandom_range(0, 99) < 4) val = '0;
      end
      send_request(kind, pos, val);
   endtask

   // Reset, directed requests, random requests, then drain and report.
   initial begin
      int  n;
      bit  growing;
      int  full_seen;
      int  low_mark;
      list_model      = new();
      steady          = 1'b0;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.req_type = RQ_APPEND;
      req_if.position = '0;
      req_if.value    = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: null handles, empty list, list edges, every request type.
      send_request(RQ_APPEND, 6'd0, 32'h0);
      send_request(RQ_GET, 6'd0, 32'h0);
      send_request(RQ_REMOVE, 6'd0, 32'h0);
      send_request(RQ_FIND, 6'd0, 32'h5);
      send_request(RQ_SET, 6'd0, 32'h1);
      pause_requests(pick_gap());
      send_request(RQ_APPEND, 6'd0, 32'hFFFF_FFFF);
      send_request(RQ_APPEND, 6'd63, 32'h0000_0001);
      send_request(RQ_INSERT, 6'd0, 32'h8000_0000);
      send_request(RQ_INSERT, 6'd3, 32'h1234_5678);
      send_request(RQ_INSERT, 6'd5, 32'h0000_0042);
      send_request(RQ_INSERT, 6'd63, 32'h0);
      pause_requests(pick_gap());
      send_request(RQ_SET, 6'd1, 32'hA5A5_A5A5);
      send_request(RQ_SET, 6'd63, 32'h0000_0007);
      send_request(RQ_GET, 6'd3, 32'h0);
      send_request(RQ_GET, 6'd63, 32'hFFFF_FFFF);
      send_request(RQ_FIND, 6'd0, 32'h1234_5678);
      send_request(RQ_FIND, 6'd0, 32'hDEAD_BEEF);
      send_request(RQ_FIND, 6'd0, 32'h0);
      send_request(RQ_REMOVE, 6'd1, 32'h0);
      send_request(RQ_REMOVE, 6'd63, 32'h0);
      send_request(RQ_UNUSED, 6'd63, 32'hFFFF_FFFF);
      send_request(RQ_CLEAR, 6'd0, 32'h0);
      send_request(RQ_GET, 6'd0, 32'h0);
      send_request(RQ_REMOVE, 6'd0, 32'h0);

      // Random part: fill the list to full, linger there, then drain it again.
      growing   = 1'b1;
      full_seen = 0;
      low_mark  = 0;
      for (n = 0; n < 400; n++) begin
         steady = (n >= 150 && n < 220);
         if (growing && list_model.used == CAPACITY) begin
            full_seen++;
            if (full_seen > $urandom_range(3, 6)) begin
               growing  = 1'b0;
               low_mark = $urandom_range(0, 8);
            end
         end else if (!growing && list_model.used <= low_mark) begin
            growing   = 1'b1;
            full_seen = 0;
         end
         send_random(growing);
         pause_requests(pick_gap());
      end
      steady = 1'b0;
      pause_requests(1);

      // Drain outstanding responses, then allow for a late extra one.
      while (list_model.pending() != 0) @(posedge clock);
      repeat (CAPACITY + 16) @(posedge clock);
      if (list_model.errors == 0 && list_model.pending() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
